[design/dnfu_pkg.sv]
// ----------------------------------------------------------------------------
// dnfu_pkg
// Shared constants and types for the diagonal Newton factor update block.
// ----------------------------------------------------------------------------
`default_nettype none
package dnfu_pkg;

    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_MAX_INNER = 64;
    localparam int DEF_MAX_COLS  = 16;
    localparam int DEF_FRAC_BITS = 16;

    localparam int IDX_W    = 6;
    localparam int VAL_W    = 32;
    localparam int OP_W     = 3;
    localparam int TDATA_W  = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 31;
    localparam int STEP_W   = 17;
    localparam int DAMP_W   = 31;
    localparam int LEN_W    = 7;
    localparam int ACC_W    = 64;

    localparam logic [STEP_W-1:0] STEP_ONE = 17'd65536;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_U   = 3'd0,
        OP_LOAD_V   = 3'd1,
        OP_LOAD_G   = 3'd2,
        OP_LOAD_C   = 3'd3,
        OP_LOAD_PEN = 3'd4,
        OP_UPDATE   = 3'd5,
        OP_READ_U   = 3'd6,
        OP_NONE     = 3'd7
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP    = 2'd0,
        CFG_DAMP    = 2'd1,
        CFG_LEN     = 2'd2,
        CFG_UNUSED  = 2'd3
    } t_cfg_index;

endpackage
`default_nettype wire

[design/diagonal_newton_factor_update.sv]
// ----------------------------------------------------------------------------
// diagonal_newton_factor_update
// Loads factor, gradient, curvature and penalty stores; updates or reads one
// factor element per item with a diagonal Newton step.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata: first_index, second_index,
//                                         load_value; tuser: opcode
//  m_axis    out  tvalid/tready           tdata: result_value, out_row,
//                                         out_column; tuser: status
//  cfg       in   valid/ready             index, data
//
//  Load items are written while idle. A read passes UREAD and FIN. An update
//  runs L pipelined dot product steps (L = inner length) over the three
//  inner memories, then, unless cut short, a bit-serial quotient and a
//  bit-serial step fraction. No reset sweep; stores are undefined until loaded.
//  Input stays ready while a result waits at the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module diagonal_newton_factor_update #(
    parameter int MAX_ROWS  = dnfu_pkg::DEF_MAX_ROWS,
    parameter int MAX_INNER = dnfu_pkg::DEF_MAX_INNER,
    parameter int MAX_COLS  = dnfu_pkg::DEF_MAX_COLS,
    parameter int FRAC_BITS = dnfu_pkg::DEF_FRAC_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // first_index[5:0], second_index[11:6], load_value[43:12], zero fill
    input  wire logic [dnfu_pkg::TDATA_W-1:0]    i_s_axis_tdata,
    // opcode[2:0]
    input  wire logic [dnfu_pkg::OP_W-1:0]       i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // result_value[31:0], out_row[37:32], out_column[43:38], zero fill
    output logic [dnfu_pkg::TDATA_W-1:0]         o_m_axis_tdata,
    // status[0]
    output logic                                 o_m_axis_tuser,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [dnfu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dnfu_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import dnfu_pkg::*;

    localparam int U_D  = MAX_ROWS * MAX_COLS;
    localparam int V_D  = MAX_INNER * MAX_COLS;
    localparam int G_D  = MAX_ROWS * MAX_INNER;
    localparam int U_AW = (U_D > 1) ? $clog2(U_D) : 1;
    localparam int V_AW = (V_D > 1) ? $clog2(V_D) : 1;
    localparam int G_AW = (G_D > 1) ? $clog2(G_D) : 1;
    localparam int P_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0] S32_MIN = -64'sd2147483648;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_UREAD = 10'b0000000010,
        S_DOT   = 10'b0000000100,
        S_DRAIN = 10'b0000001000,
        S_PREP  = 10'b0000010000,
        S_SIGN  = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_BIG   = 10'b0010000000,
        S_FMD   = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } t_state;

    function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] p);
        logic signed [ACC_W-1:0] b;
        b = p + HALF;
        rnd = b >>> FRAC_BITS;
    endfunction

    logic signed [VAL_W-1:0] u_mem [U_D];
    logic signed [VAL_W-1:0] v_mem [V_D];
    logic signed [VAL_W-1:0] g_mem [G_D];
    logic signed [VAL_W-1:0] c_mem [G_D];
    logic signed [VAL_W-1:0] p_mem [MAX_COLS];

    t_state r_state, n_state;

    logic [STEP_W-1:0] r_step;
    logic [DAMP_W-1:0] r_damp;
    logic [LEN_W-1:0]  r_inner;

    t_opcode               w_op;
    logic [IDX_W-1:0]      w_a, w_b;
    logic signed [VAL_W-1:0] w_val;
    logic                  w_acc, w_row_ok, w_col_ok, w_inr_ok, w_inc_ok, w_go;

    logic [IDX_W-1:0]        r_a, r_b;
    logic                    r_isread;
    logic signed [VAL_W-1:0] r_u, r_pen;
    logic signed [ACC_W-1:0] r_up;
    logic [LEN_W-1:0]        r_k, r_len;
    logic [3:0]              r_pv;
    logic signed [VAL_W-1:0] r_vd, r_gd, r_cd, r_c1, r_c2, r_sq;
    logic signed [ACC_W-1:0] r_pg, r_pvv, r_rg, r_pc, r_sd, r_sc, r_g, r_c;
    logic [ACC_W-1:0]        r_ag, r_ac, r_dq, r_rem, r_r0, r_mq;
    logic                    r_neg, r_czero, r_big, r_phase;
    logic [LEN_W-1:0]        r_cnt;
    logic [4:0]              r_bit;
    logic [STEP_W:0]         r_fq;
    logic                    r_ovalid;
    logic [TDATA_W-1:0]      r_odata;
    logic                    r_ostat;

    logic                    w_issue, w_out_free;
    logic [ACC_W:0]          w_dsh, w_fsh;
    logic                    w_dge, w_fge;
    logic signed [ACC_W-1:0] w_rv, w_delta, w_wide, w_sum;
    logic signed [VAL_W-1:0] w_nv;
    logic                    w_st;
    logic [LEN_W-1:0]        w_len;

    assign w_op     = t_opcode'(i_s_axis_tuser);
    assign w_a      = i_s_axis_tdata[5:0];
    assign w_b      = i_s_axis_tdata[11:6];
    assign w_val    = i_s_axis_tdata[43:12];
    assign w_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_row_ok = int'(w_a) < MAX_ROWS;
    assign w_col_ok = int'(w_b) < MAX_COLS;
    assign w_inr_ok = int'(w_a) < MAX_INNER;
    assign w_inc_ok = int'(w_b) < MAX_INNER;
    assign w_go     = w_acc && (w_op == OP_UPDATE || w_op == OP_READ_U) && w_row_ok && w_col_ok;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ostat;

    assign w_issue    = (r_state == S_DOT);
    assign w_out_free = !r_ovalid || i_m_axis_tready;

    assign w_dsh = {r_rem, r_dq[ACC_W-1]};
    assign w_dge = w_dsh >= {1'b0, r_ac};
    assign w_fsh = r_phase ? ({1'b0, r_rem} + {1'b0, r_r0}) : {r_rem, 1'b0};
    assign w_fge = w_fsh >= {1'b0, r_ac};

    always_comb begin
        w_rv = rnd(r_pvv);
        if (r_inner == '0) begin
            w_len = LEN_W'(1);
        end else if (int'(r_inner) > MAX_INNER) begin
            w_len = LEN_W'(MAX_INNER);
        end else begin
            w_len = r_inner;
        end
    end

    always_comb begin
        w_delta = signed'(r_mq + ACC_W'(r_fq));
        w_wide  = r_neg ? (ACC_W'(r_u) + w_delta) : (ACC_W'(r_u) - w_delta);
        w_sum   = '0;
        w_st    = 1'b0;
        w_nv    = r_u;
        if (r_isread) begin
            w_nv = r_u;
        end else if (r_czero) begin
            w_st = 1'b1;
            if (r_g > 0) begin
                w_nv = S32_MIN[VAL_W-1:0];
            end else if (r_g < 0) begin
                w_nv = S32_MAX[VAL_W-1:0];
            end
        end else if (r_big) begin
            w_st = 1'b1;
            w_nv = r_neg ? S32_MAX[VAL_W-1:0] : S32_MIN[VAL_W-1:0];
        end else begin
            w_sum = w_wide;
            if (w_sum > S32_MAX) begin
                w_nv = S32_MAX[VAL_W-1:0];
                w_st = 1'b1;
            end else if (w_sum < S32_MIN) begin
                w_nv = S32_MIN[VAL_W-1:0];
                w_st = 1'b1;
            end else begin
                w_nv = w_sum[VAL_W-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_go) n_state = S_UREAD;
            S_UREAD: n_state = r_isread ? S_FIN : S_DOT;
            S_DOT:   if (r_k == r_len - LEN_W'(1)) n_state = S_DRAIN;
            S_DRAIN: if (r_pv == '0) n_state = S_PREP;
            S_PREP:  n_state = S_SIGN;
            S_SIGN:  n_state = (r_c == '0) ? S_FIN : S_DIV;
            S_DIV:   if (r_cnt == LEN_W'(ACC_W - 1)) n_state = S_BIG;
            S_BIG:   n_state = (r_step != '0 && r_dq[ACC_W-1:34] != '0) ? S_FIN : S_FMD;
            S_FMD:   if (r_phase && r_bit == '0) n_state = S_FIN;
            S_FIN:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_pv     <= '0;
            r_step   <= STEP_ONE;
            r_damp   <= '0;
            r_inner  <= LEN_W'(64);
        end else begin
            r_state <= n_state;
            r_pv    <= {r_pv[2:0], w_issue};
            if (r_state == S_FIN && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_STEP: r_step <= (i_cfg_data[STEP_W-1:0] > STEP_ONE) ? STEP_ONE
                                                                        : i_cfg_data[STEP_W-1:0];
                    CFG_DAMP: r_damp <= i_cfg_data[DAMP_W-1:0];
                    CFG_LEN:  r_inner <= i_cfg_data[LEN_W-1:0];
                    default:  ;
                endcase
            end
        end
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (w_acc && w_op == OP_LOAD_U && w_row_ok && w_col_ok) begin
            u_mem[U_AW'(int'(w_a) * MAX_COLS + int'(w_b))] <= w_val;
        end else if (r_state == S_FIN && w_out_free && !r_isread) begin
            u_mem[U_AW'(int'(r_a) * MAX_COLS + int'(r_b))] <= w_nv;
        end
        if (w_acc && w_op == OP_LOAD_V && w_inr_ok && w_col_ok) begin
            v_mem[V_AW'(int'(w_a) * MAX_COLS + int'(w_b))] <= w_val;
        end
        if (w_acc && w_op == OP_LOAD_G && w_row_ok && w_inc_ok) begin
            g_mem[G_AW'(int'(w_a) * MAX_INNER + int'(w_b))] <= w_val;
        end
        if (w_acc && w_op == OP_LOAD_C && w_row_ok && w_inc_ok) begin
            c_mem[G_AW'(int'(w_a) * MAX_INNER + int'(w_b))] <= w_val;
        end
        if (w_acc && w_op == OP_LOAD_PEN && w_col_ok) begin
            p_mem[P_AW'(w_b)] <= w_val;
        end
        if (w_go) begin
            r_u   <= u_mem[U_AW'(int'(w_a) * MAX_COLS + int'(w_b))];
            r_pen <= p_mem[P_AW'(w_b)];
        end
        if (w_issue) begin
            r_vd <= v_mem[V_AW'(int'(r_k) * MAX_COLS + int'(r_b))];
            r_gd <= g_mem[G_AW'(int'(r_a) * MAX_INNER + int'(r_k))];
            r_cd <= c_mem[G_AW'(int'(r_a) * MAX_INNER + int'(r_k))];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_a      <= w_a;
            r_b      <= w_b;
            r_isread <= (w_op == OP_READ_U);
        end
        // dot product pipeline
        if (r_pv[0]) begin
            r_pg  <= r_gd * r_vd;
            r_pvv <= r_vd * r_vd;
            r_c1  <= r_cd;
        end
        if (r_pv[1]) begin
            r_rg <= rnd(r_pg);
            r_sq <= (w_rv > S32_MAX) ? S32_MAX[VAL_W-1:0] : w_rv[VAL_W-1:0];
            r_c2 <= r_c1;
        end
        if (r_pv[2]) begin
            r_sd <= r_sd + r_rg;
            r_pc <= r_c2 * r_sq;
        end
        if (r_pv[3]) begin
            r_sc <= r_sc + rnd(r_pc);
        end
        unique case (r_state)
            S_UREAD: begin
                r_up     <= r_u * r_pen;
                r_sd     <= '0;
                r_sc     <= '0;
                r_k      <= '0;
                r_len    <= w_len;
                r_czero  <= 1'b0;
                r_big    <= 1'b0;
            end
            S_DOT: r_k <= r_k + LEN_W'(1);
            S_PREP: begin
                r_g <= rnd(r_up) - r_sd;
                r_c <= r_sc + ACC_W'(r_pen) + signed'(ACC_W'(r_damp));
            end
            S_SIGN: begin
                r_ag    <= (r_g < 0) ? ACC_W'(-r_g) : ACC_W'(r_g);
                r_ac    <= (r_c < 0) ? ACC_W'(-r_c) : ACC_W'(r_c);
                r_neg   <= (r_g < 0) != (r_c < 0);
                r_czero <= (r_c == '0);
                r_dq    <= (r_g < 0) ? ACC_W'(-r_g) : ACC_W'(r_g);
                r_rem   <= '0;
                r_cnt   <= '0;
            end
            S_DIV: begin
                r_cnt <= r_cnt + LEN_W'(1);
                r_dq  <= {r_dq[ACC_W-2:0], w_dge};
                r_rem <= w_dge ? ACC_W'(w_dsh - {1'b0, r_ac}) : w_dsh[ACC_W-1:0];
            end
            S_BIG: begin
                r_big   <= (r_step != '0 && r_dq[ACC_W-1:34] != '0);
                r_mq    <= ACC_W'(r_step) * ACC_W'(r_dq[33:0]);
                r_r0    <= r_rem;
                r_rem   <= '0;
                r_fq    <= '0;
                r_bit   <= 5'(STEP_W - 1);
                r_phase <= 1'b0;
            end
            S_FMD: begin
                r_phase <= !r_phase;
                if (!r_phase) begin
                    r_fq  <= {r_fq[STEP_W-1:0], w_fge};
                    r_rem <= w_fge ? ACC_W'(w_fsh - {1'b0, r_ac}) : w_fsh[ACC_W-1:0];
                end else begin
                    r_bit <= r_bit - 5'd1;
                    if (r_step[r_bit]) begin
                        r_fq  <= r_fq + (STEP_W+1)'(w_fge);
                        r_rem <= w_fge ? ACC_W'(w_fsh - {1'b0, r_ac}) : w_fsh[ACC_W-1:0];
                    end
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    r_odata <= {4'b0, r_b, r_a, w_nv};
                    r_ostat <= w_st;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[design/dnfu_check.sv]
// ----------------------------------------------------------------------------
// dnfu_check
// Port-level checks for the diagonal Newton factor update block.
// ----------------------------------------------------------------------------
`default_nettype none
module dnfu_check (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_axis_tvalid,
    input wire logic                            o_s_axis_tready,
    input wire logic [dnfu_pkg::TDATA_W-1:0]    i_s_axis_tdata,
    input wire logic [dnfu_pkg::OP_W-1:0]       i_s_axis_tuser,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [dnfu_pkg::TDATA_W-1:0]    o_m_axis_tdata,
    input wire logic                            o_m_axis_tuser,
    input wire logic                            i_cfg_valid,
    input wire logic                            o_cfg_ready,
    input wire logic [dnfu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [dnfu_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import dnfu_pkg::*;

    logic w_acc, w_load, w_busy_op;

    assign w_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load = i_s_axis_tuser == OP_LOAD_U || i_s_axis_tuser == OP_LOAD_V ||
                    i_s_axis_tuser == OP_LOAD_G || i_s_axis_tuser == OP_LOAD_C ||
                    i_s_axis_tuser == OP_LOAD_PEN;
    assign w_busy_op = (i_s_axis_tuser == OP_UPDATE || i_s_axis_tuser == OP_READ_U) &&
                       int'(i_s_axis_tdata[5:0]) < DEF_MAX_ROWS &&
                       int'(i_s_axis_tdata[11:6]) < DEF_MAX_COLS;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_load |=> o_s_axis_tready)
        else $error("load item left input not ready");

    a_op_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_busy_op |=> !o_s_axis_tready)
        else $error("update or read item did not occupy the block");

    a_out_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> int'(o_m_axis_tdata[37:32]) < DEF_MAX_ROWS &&
                            int'(o_m_axis_tdata[43:38]) < DEF_MAX_COLS)
        else $error("result index out of range");

endmodule

bind diagonal_newton_factor_update dnfu_check u_dnfu_check (.*);
`default_nettype wire
